>>> rtl/core/bitmap_coordinate_rank_select_core_defines.svh
// ---------------------------------------------------------------------------
// Bitmap coordinate rank/select core - assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef BITMAP_COORDINATE_RANK_SELECT_CORE_DEFINES_SVH
`define BITMAP_COORDINATE_RANK_SELECT_CORE_DEFINES_SVH

// same-cycle implication
`define BCRS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bcrs_pkg.sv
// ---------------------------------------------------------------------------
// bcrs_pkg
// Types, constants and helper functions of the bitmap rank/select core.
// ---------------------------------------------------------------------------
package bcrs_pkg;

  localparam int NUM_STATES = 4096;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = NUM_STATES / WORD_BITS;
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int CNT_W      = BIT_W + 1;
  localparam int COORD_W    = 12;
  localparam int POS_W      = $clog2(NUM_STATES);
  localparam int SCNT_W     = POS_W + 1;
  localparam int BYTES      = WORD_BITS / 8;
  localparam int BYTE_W     = $clog2(BYTES);

  typedef enum logic [2:0] {
    KIND_WR_REM      = 3'd0,
    KIND_WR_REACH    = 3'd1,
    KIND_ORIG2REM    = 3'd2,
    KIND_ORIG2REACH  = 3'd3,
    KIND_REM2ORIG    = 3'd4,
    KIND_REM2REACH   = 3'd5,
    KIND_REACH2ORIG  = 3'd6,
    KIND_REACH2REM   = 3'd7
  } bcrs_kind_e;

  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_NOT_MEMBER   = 2'd1,
    STAT_OUT_OF_RANGE = 2'd2
  } bcrs_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_RANK,
    S_SELECT,
    S_PICK_BYTE,
    S_PICK_BIT
  } bcrs_state_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic [COORD_W-1:0] coord;
    logic               bit_value;
  } bcrs_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] converted;
    logic [1:0]         status;
  } bcrs_out_t;

  typedef struct packed {
    logic                 rem_we;
    logic                 rch_we;
    logic [WADDR_W-1:0]   addr;
    logic [WORD_BITS-1:0] data;
  } bcrs_wr_t;

  function automatic logic [CNT_W-1:0] popcnt(input logic [WORD_BITS-1:0] w);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + CNT_W'(w[i]);
    end
    return n;
  endfunction

  function automatic logic [3:0] popcnt8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

endpackage

>>> rtl/core/bitmap_coordinate_rank_select_core.sv
// ---------------------------------------------------------------------------
// bitmap_coordinate_rank_select_core
// Coordinate conversion between original, remaining and reachable numberings
// by rank and select over two bitmaps scanned one 64-bit word per cycle.
// ---------------------------------------------------------------------------
// Bit writes pass through S_WRITE and give no result. Rank scans words up to
// the one holding coord. Select scans to the word of the hit, then picks the
// byte and the bit; rem2reach/reach2rem run a select and then a rank.
// busy drops as done_o rises, so the next transaction can be taken while done_o is high.
// Reset leaves both maps all ones at once (per-row valid bits, no clear pass).
// done_o pulses for one cycle per result; the receiver cannot stall.
module bitmap_coordinate_rank_select_core
  import bcrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  bcrs_in_t  item_i,
  output logic      done_o,
  output bcrs_out_t result_o
);

  bcrs_state_e          state_q, state_d;
  bcrs_kind_e           kind_q, kind_d;
  logic [COORD_W-1:0]   coord_q, coord_d;
  logic                 bitv_q, bitv_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [SCNT_W-1:0]    cnt_q, cnt_d;
  logic [WADDR_W:0]     iss_q, iss_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [WADDR_W-1:0]   wsel_q, wsel_d;
  logic [BIT_W-1:0]     resid_q, resid_d;
  logic [BYTE_W-1:0]    byte_q, byte_d;
  logic [2:0]           rb_q, rb_d;
  logic                 done_q, done_d;
  bcrs_out_t            res_q, res_d;
  logic                 rdv_q;
  logic [WADDR_W-1:0]   rd_addr_q;

  logic                 rd_en;
  logic [WADDR_W-1:0]   rd_addr;
  bcrs_wr_t             wr_req;
  logic [WORD_BITS-1:0] rem_rdata, rch_rdata;

  logic [WORD_BITS-1:0] sel_map, cnt_map, chk_map, below_mask, wr_word;
  logic                 chk_en;
  logic [WADDR_W-1:0]   last_w;
  logic [CNT_W-1:0]     sel_pc;
  logic [SCNT_W-1:0]    sel_sum;
  logic [BYTE_W-1:0]    pick_byte;
  logic [2:0]           pick_rb;
  logic [2:0]           pick_bit;
  logic [POS_W-1:0]     sel_pos;

  bcrs_bitmap_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .wr_i       (wr_req),
    .rem_rdata_o(rem_rdata),
    .rch_rdata_o(rch_rdata)
  );

  always_comb begin
    sel_map = rem_rdata;
    cnt_map = rem_rdata;
    chk_map = rem_rdata;
    chk_en  = 1'b1;
    case (kind_q)
      KIND_ORIG2REACH: begin
        cnt_map = rch_rdata;
        chk_map = rch_rdata;
      end
      KIND_REACH2ORIG: begin
        sel_map = rch_rdata;
      end
      KIND_REM2REACH: begin
        cnt_map = rem_rdata & rch_rdata;
        chk_map = rch_rdata;
      end
      KIND_REACH2REM: begin
        sel_map = rem_rdata & rch_rdata;
        chk_en  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      below_mask[i] = (BIT_W'(i) < pos_q[BIT_W-1:0]);
    end
  end

  always_comb begin
    wr_word = (kind_q == KIND_WR_REACH) ? rch_rdata : rem_rdata;
    wr_word[coord_q[BIT_W-1:0]] = bitv_q;
  end

  assign last_w  = pos_q[POS_W-1:BIT_W];
  assign sel_pc  = popcnt(sel_map);
  assign sel_sum = cnt_q + SCNT_W'(sel_pc);

  // byte holding the wanted set bit
  always_comb begin
    logic [CNT_W-1:0] acc;
    logic [3:0]       pc;
    logic             found;
    acc       = '0;
    found     = 1'b0;
    pick_byte = '0;
    pick_rb   = '0;
    for (int i = 0; i < BYTES; i++) begin
      pc = popcnt8(word_q[i*8 +: 8]);
      if (!found && ({1'b0, resid_q} < acc + CNT_W'(pc))) begin
        found     = 1'b1;
        pick_byte = BYTE_W'(i);
        pick_rb   = 3'({1'b0, resid_q} - acc);
      end
      acc = acc + CNT_W'(pc);
    end
  end

  // bit inside that byte
  always_comb begin
    logic [7:0] b;
    logic [3:0] seen;
    logic       found;
    b        = word_q[byte_q*8 +: 8];
    seen     = '0;
    found    = 1'b0;
    pick_bit = '0;
    for (int j = 0; j < 8; j++) begin
      if (!found && b[j]) begin
        if (seen == {1'b0, rb_q}) begin
          found    = 1'b1;
          pick_bit = 3'(j);
        end
        seen = seen + 4'd1;
      end
    end
  end

  assign sel_pos = {wsel_q, byte_q, pick_bit};

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    coord_d = coord_q;
    bitv_d  = bitv_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    iss_d   = iss_q;
    word_d  = word_q;
    wsel_d  = wsel_q;
    resid_d = resid_q;
    byte_d  = byte_q;
    rb_d    = rb_q;
    done_d  = 1'b0;
    res_d   = res_q;
    rd_en   = 1'b0;
    rd_addr = iss_q[WADDR_W-1:0];
    wr_req  = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_d  = bcrs_kind_e'(item_i.kind);
          coord_d = item_i.coord;
          bitv_d  = item_i.bit_value;
          pos_d   = item_i.coord;
          rd_en   = 1'b1;
          case (bcrs_kind_e'(item_i.kind))
            KIND_WR_REM, KIND_WR_REACH: begin
              rd_addr = item_i.coord[POS_W-1:BIT_W];
              state_d = S_WRITE;
            end
            KIND_ORIG2REM, KIND_ORIG2REACH: begin
              rd_addr = '0;
              iss_d   = (WADDR_W+1)'(1);
              cnt_d   = '0;
              state_d = S_RANK;
            end
            default: begin
              rd_addr = '0;
              iss_d   = (WADDR_W+1)'(1);
              cnt_d   = '0;
              state_d = S_SELECT;
            end
          endcase
        end
      end

      S_WRITE: begin
        wr_req.rem_we = (kind_q == KIND_WR_REM);
        wr_req.rch_we = (kind_q == KIND_WR_REACH);
        wr_req.addr   = coord_q[POS_W-1:BIT_W];
        wr_req.data   = wr_word;
        state_d       = S_IDLE;
      end

      S_RANK: begin
        if (iss_q <= {1'b0, last_w}) begin
          rd_en = 1'b1;
          iss_d = iss_q + 1'b1;
        end
        if (rdv_q) begin
          if (rd_addr_q != last_w) begin
            cnt_d = cnt_q + SCNT_W'(popcnt(cnt_map));
          end else begin
            state_d = S_IDLE;
            done_d  = 1'b1;
            if (chk_en && !chk_map[pos_q[BIT_W-1:0]]) begin
              res_d.converted = '0;
              res_d.status    = STAT_NOT_MEMBER;
            end else begin
              res_d.converted = COORD_W'(cnt_q + SCNT_W'(popcnt(cnt_map & below_mask)));
              res_d.status    = STAT_OK;
            end
          end
        end
      end

      S_SELECT: begin
        if (!iss_q[WADDR_W]) begin
          rd_en = 1'b1;
          iss_d = iss_q + 1'b1;
        end
        if (rdv_q) begin
          if (sel_sum > SCNT_W'(coord_q)) begin
            word_d  = sel_map;
            wsel_d  = rd_addr_q;
            resid_d = BIT_W'(SCNT_W'(coord_q) - cnt_q);
            state_d = S_PICK_BYTE;
          end else begin
            cnt_d = sel_sum;
            if (rd_addr_q == '1) begin
              state_d         = S_IDLE;
              done_d          = 1'b1;
              res_d.converted = '0;
              res_d.status    = STAT_OUT_OF_RANGE;
            end
          end
        end
      end

      S_PICK_BYTE: begin
        byte_d  = pick_byte;
        rb_d    = pick_rb;
        state_d = S_PICK_BIT;
      end

      S_PICK_BIT: begin
        if (kind_q == KIND_REM2ORIG || kind_q == KIND_REACH2ORIG) begin
          state_d         = S_IDLE;
          done_d          = 1'b1;
          res_d.converted = COORD_W'(sel_pos);
          res_d.status    = STAT_OK;
        end else begin
          pos_d   = sel_pos;
          rd_en   = 1'b1;
          rd_addr = '0;
          iss_d   = (WADDR_W+1)'(1);
          cnt_d   = '0;
          state_d = S_RANK;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iss_q   <= '0;
      rdv_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      rdv_q   <= rd_en;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    coord_q <= coord_d;
    bitv_q  <= bitv_d;
    pos_q   <= pos_d;
    cnt_q   <= cnt_d;
    word_q  <= word_d;
    wsel_q  <= wsel_d;
    resid_q <= resid_d;
    byte_q  <= byte_d;
    rb_q    <= rb_d;
    res_q   <= res_d;
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

>>> rtl/core/bcrs_bitmap_mem.sv
// ---------------------------------------------------------------------------
// bcrs_bitmap_mem
// Remain and reach bitmaps, one word per row, registered read.
// Rows never written read as all ones through per-row valid bits.
// ---------------------------------------------------------------------------
module bcrs_bitmap_mem
  import bcrs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [WADDR_W-1:0]   rd_addr_i,
  input  bcrs_wr_t             wr_i,
  output logic [WORD_BITS-1:0] rem_rdata_o,
  output logic [WORD_BITS-1:0] rch_rdata_o
);

  logic [WORD_BITS-1:0] rem_mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rch_mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rem_rd_q, rch_rd_q;
  logic [NUM_WORDS-1:0] rem_vld_q, rch_vld_q;
  logic                 rem_rv_q, rch_rv_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.rem_we) begin
      rem_mem[wr_i.addr] <= wr_i.data;
    end
    if (wr_i.rch_we) begin
      rch_mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rem_rd_q <= rem_mem[rd_addr_i];
      rch_rd_q <= rch_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_vld_q <= '0;
      rch_vld_q <= '0;
      rem_rv_q  <= 1'b0;
      rch_rv_q  <= 1'b0;
    end else begin
      if (wr_i.rem_we) begin
        rem_vld_q[wr_i.addr] <= 1'b1;
      end
      if (wr_i.rch_we) begin
        rch_vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rem_rv_q <= rem_vld_q[rd_addr_i];
        rch_rv_q <= rch_vld_q[rd_addr_i];
      end
    end
  end

  assign rem_rdata_o = rem_rv_q ? rem_rd_q : '1;
  assign rch_rdata_o = rch_rv_q ? rch_rd_q : '1;

endmodule

>>> rtl/core/bcrs_checker.sv
// ---------------------------------------------------------------------------
// bcrs_checker
// Port-level checks of the bitmap rank/select core, bound to the top level.
// ---------------------------------------------------------------------------
`include "bitmap_coordinate_rank_select_core_defines.svh"

module bcrs_checker
  import bcrs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input bcrs_in_t  item_i,
  input logic      done_o,
  input bcrs_out_t result_o
);

  logic wr_acc;
  logic q_acc;

  assign wr_acc = start && !busy &&
                  (item_i.kind == KIND_WR_REM || item_i.kind == KIND_WR_REACH);
  assign q_acc  = start && !busy && !wr_acc;

  `BCRS_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "back-to-back results")
  `BCRS_ASSERT_SAME(a_status_legal, clk_i, rst_ni, done_o, (result_o.status == STAT_OK || result_o.status == STAT_NOT_MEMBER || result_o.status == STAT_OUT_OF_RANGE), "illegal status")
  `BCRS_ASSERT_SAME(a_err_zero, clk_i, rst_ni, done_o && result_o.status != STAT_OK, result_o.converted == '0, "nonzero coordinate on error")
  `BCRS_ASSERT_NEXT(a_write_quiet, clk_i, rst_ni, wr_acc, busy && !done_o ##1 !busy && !done_o, "write transaction misbehaved")
  `BCRS_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, q_acc, busy && !done_o, "query transaction not started")

endmodule

bind bitmap_coordinate_rank_select_core bcrs_checker u_bcrs_checker (.*);
